### src/i2cm_pkg.sv
// Shared types and command codes for the I2C bit-level master.
package i2cm_pkg;

   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_CHECK = 3'd5;
   localparam logic [2:0] OP_MACK  = 3'd6;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_seen;
   } rsp_type;

   // Classified tick: op is OP_IDLE when the tick carries no usable command.
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data_byte;
      logic       sda_in;
   } item_type;

endpackage

### src/i2c_bit_level_master_top.sv
// Top level of the I2C bit-level master: front end, request queue, bus engine.
// Usage:
//   Each request on req_* is one timer tick: a command code (start, stop, write
//   byte, read byte, check ack, master ack, or none), a data byte for writes and
//   the sampled SDA level. Every request yields exactly one response on rsp_*
//   carrying the SCL level, SDA release, busy, done pulse, last read byte and
//   last acknowledge result after that tick. Commands arriving while busy are
//   dropped. csr_wr_en/csr_wr_data set the half period (ticks per bus phase);
//   write it only while no request is outstanding.
//   Path: an accepted request is written into the queue, stepped by the engine
//   when it reaches the head of the queue, and its response is registered.
//   Throughput: one request per cycle while rsp_stall is low, set by the
//   single-tick engine step (16-bit timer add and compare plus phase update).
//   Stall: when rsp_stall holds the response, the engine pauses and the queue
//   (QUEUE_DEPTH entries) keeps taking requests until it fills; then req_stall
//   rises. Reset idles the engine with both lines released, empties the queue
//   and restores the half period to 250.
module i2c_bit_level_master_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type push_item;
   item_type q_item;

   i2cm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   i2cm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // A full queue always has a request to offer the engine.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> q_valid)
      else $error("queue reports full while empty");

   // A finishing tick never reports busy.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done and busy together");

   // No response right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

### src/i2cm_front.sv
// Front end: takes requests and classifies the command of each tick.
module i2cm_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output i2cm_pkg::item_type q_item
);
   import i2cm_pkg::*;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_item.data_byte = req_data.data_byte;
      q_item.sda_in    = req_data.sda_in;
      case (req_data.cmd)
         OP_START, OP_STOP, OP_WRITE, OP_READ, OP_CHECK, OP_MACK: q_item.op = req_data.cmd;
         default: q_item.op = OP_IDLE;
      endcase
   end

endmodule

### src/i2cm_fifo.sv
// Short request queue between the front end and the bus engine.
module i2cm_fifo #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  i2cm_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               out_valid,
   output i2cm_pkg::item_type out_item
);
   import i2cm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/i2cm_engine.sv
// Back end: bus phase sequencer, half-period timer and result register.
module i2cm_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               q_valid,
   input  i2cm_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cm_pkg::rsp_type  rsp_data
);
   import i2cm_pkg::*;

   logic [15:0] half_period_ff;
   logic [2:0]  op_ff, op_in;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in_lvl;
   logic        ack_ff, ack_in;
   logic [7:0]  read_hold_ff, read_hold_in;
   logic        done;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [15:0] tick_inc;
   logic [4:0]  phase_inc;

   function automatic logic [4:0] phase_total(input logic [2:0] op);
      case (op)
         OP_START, OP_STOP, OP_CHECK: phase_total = 5'd3;
         OP_WRITE, OP_READ:           phase_total = 5'd16;
         OP_MACK:                     phase_total = 5'd2;
         default:                     phase_total = 5'd0;
      endcase
   endfunction

   // Pin levels {scl, sda} on entry to a phase.
   function automatic logic [1:0] phase_pins(input logic [2:0] op, input logic [4:0] ph,
                                             input logic [7:0] shift, input logic scl,
                                             input logic sda);
      logic s_c;
      logic s_d;
      s_c = scl;
      s_d = sda;
      case (op)
         OP_START: begin
            if (ph == 5'd0) begin
               s_c = 1'b1;
               s_d = 1'b1;
            end else if (ph == 5'd1) begin
               s_d = 1'b0;
            end else begin
               s_c = 1'b0;
            end
         end
         OP_STOP: begin
            if (ph == 5'd0) begin
               s_c = 1'b1;
               s_d = 1'b0;
            end else if (ph == 5'd1) begin
               s_d = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         OP_WRITE: begin
            if (!ph[0]) begin
               s_d = shift[3'd7 - ph[3:1]];
               s_c = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         OP_READ: begin
            if (!ph[0]) begin
               s_c = 1'b1;
               s_d = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         OP_CHECK: begin
            if (ph == 5'd0) begin
               s_c = 1'b1;
               s_d = 1'b1;
            end else if (ph == 5'd2) begin
               s_c = 1'b0;
            end
         end
         OP_MACK: begin
            if (ph == 5'd0) begin
               s_c = 1'b1;
               s_d = 1'b0;
            end else begin
               s_c = 1'b0;
            end
         end
         default: begin
         end
      endcase
      phase_pins = {s_c, s_d};
   endfunction

   // Advance one tick whenever a queued request exists and the result slot frees up.
   assign q_pop     = q_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      op_in        = op_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      scl_in       = scl_ff;
      sda_in_lvl   = sda_ff;
      ack_in       = ack_ff;
      read_hold_in = read_hold_ff;
      done         = 1'b0;
      tick_inc     = '0;
      phase_inc    = '0;

      if (op_ff == OP_IDLE && q_item.op != OP_IDLE) begin
         op_in    = q_item.op;
         phase_in = '0;
         tick_in  = '0;
         if (q_item.op == OP_WRITE) begin
            shift_in = q_item.data_byte;
         end else if (q_item.op == OP_READ) begin
            shift_in = '0;
         end
         {scl_in, sda_in_lvl} = phase_pins(q_item.op, 5'd0, shift_in, scl_in, sda_in_lvl);
      end

      if (op_in != OP_IDLE) begin
         tick_inc = tick_in + 16'd1;
         tick_in  = tick_inc;
         if (tick_inc >= half_period_ff) begin
            tick_in = '0;
            if (op_in == OP_READ && !phase_in[0]) begin
               shift_in = {shift_in[6:0], q_item.sda_in};
            end else if (op_in == OP_CHECK && phase_in == 5'd0) begin
               ack_in = ~q_item.sda_in;
            end
            phase_inc = phase_in + 5'd1;
            if (phase_inc >= phase_total(op_in)) begin
               if (op_in == OP_READ) begin
                  read_hold_in = shift_in;
               end
               op_in    = OP_IDLE;
               phase_in = '0;
               done     = 1'b1;
            end else begin
               phase_in = phase_inc;
               {scl_in, sda_in_lvl} = phase_pins(op_in, phase_inc, shift_in, scl_in,
                                                 sda_in_lvl);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_wr_en) begin
         half_period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         read_hold_ff <= '0;
      end else if (q_pop) begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in_lvl;
         ack_ff       <= ack_in;
         read_hold_ff <= read_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff.scl         <= scl_in;
         rsp_data_ff.sda_release <= sda_in_lvl;
         rsp_data_ff.busy_res    <= (op_in != OP_IDLE);
         rsp_data_ff.done_res    <= done;
         rsp_data_ff.read_data   <= read_hold_in;
         rsp_data_ff.ack_seen    <= ack_in;
      end
   end

endmodule
